// File: design/ipv4r_pkg.sv
// ----------------------------------------------------------------------------
// ipv4r_pkg
// Shared types and constants for the IPv4 receive reassembler.
// ----------------------------------------------------------------------------
package ipv4r_pkg;

   localparam int PENDING_SLOTS          = 2;
   localparam int FRAGMENTS_PER_DATAGRAM = 2;
   localparam int FRAGMENT_PAYLOAD_BYTES = 1024;
   localparam int SLOT_BYTES  = FRAGMENTS_PER_DATAGRAM * FRAGMENT_PAYLOAD_BYTES;
   localparam int STORE_BYTES = PENDING_SLOTS * SLOT_BYTES;
   localparam int SLOT_AW     = $clog2(SLOT_BYTES);
   localparam int STORE_AW    = $clog2(STORE_BYTES);
   localparam int SLOT_IW     = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] HDR_BYTES       = 16'd20;
   localparam logic [15:0] SUM_GOOD        = 16'hffff;
   localparam logic [12:0] FRAG_UNIT_RESET = 13'd128;
   localparam logic [23:0] EXPIRY_RESET    = 24'd3333333;

   localparam logic CSR_FRAG_UNIT = 1'b0;
   localparam logic CSR_EXPIRY    = 1'b1;

   typedef enum logic [4:0] {
      PH_HEADER     = 5'd0,
      PH_PLAIN_PRE0 = 5'd1,
      PH_PLAIN_PRE1 = 5'd2,
      PH_PLAIN_PRE2 = 5'd3,
      PH_PLAIN_PRE3 = 5'd4,
      PH_PLAIN_PRE4 = 5'd5,
      PH_PLAIN_PRE5 = 5'd6,
      PH_PLAIN      = 5'd7,
      PH_TO_STORE   = 5'd8,
      PH_STORE_PRE0 = 5'd9,
      PH_STORE_PRE1 = 5'd10,
      PH_STORE_PRE2 = 5'd11,
      PH_STORE_PRE3 = 5'd12,
      PH_STORE_PRE4 = 5'd13,
      PH_STORE_PRE5 = 5'd14,
      PH_FROM_STORE = 5'd15,
      PH_CSUM_ERR0  = 5'd16,
      PH_CSUM_ERR1  = 5'd17,
      PH_FRAG_ERR0  = 5'd18,
      PH_FRAG_ERR1  = 5'd19,
      PH_WAIT_END   = 5'd20
   } phase_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       out_last;
      logic       consumed;
      logic       error;
   } rsp_type;

   // result with a pending store read: byte is taken from the store data
   typedef struct packed {
      rsp_type rsp;
      logic    from_store;
   } stage_type;

endpackage

// File: design/ipv4r_engine.sv
// ----------------------------------------------------------------------------
// ipv4r_engine
// Front part: parses headers, keeps the pending table, issues store accesses.
// ----------------------------------------------------------------------------
module ipv4r_engine
   import ipv4r_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  req_type             item,
   input  logic [12:0]         frag_unit,
   input  logic [23:0]         expiry,
   output stage_type           result,
   output logic                store_we,
   output logic [STORE_AW-1:0] store_addr,
   output logic [7:0]          store_wdata
);

   phase_type   phase_ff, phase_in;
   logic [15:0] position_ff, position_in;
   logic [15:0] plen_ff, plen_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] id_ff, id_in;
   logic        mf_ff, mf_in;
   logic [12:0] fo_ff, fo_in;
   logic [31:0] src_ff, src_in;
   logic        act_ok_ff, act_ok_in;
   logic [SLOT_IW-1:0] act_ff, act_in;

   logic [PENDING_SLOTS-1:0] use_ff, use_in;
   logic [15:0] sid_ff [PENDING_SLOTS], sid_in [PENDING_SLOTS];
   logic [7:0]  arr_ff [PENDING_SLOTS], arr_in [PENDING_SLOTS];
   logic [7:0]  tot_ff [PENDING_SLOTS], tot_in [PENDING_SLOTS];
   logic [15:0] slen_ff[PENDING_SLOTS], slen_in[PENDING_SLOTS];
   logic [23:0] cnt_ff [PENDING_SLOTS], cnt_in [PENDING_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         position_ff <= '0;
         plen_ff     <= '0;
         sum_ff      <= '0;
         id_ff       <= '0;
         mf_ff       <= 1'b0;
         fo_ff       <= '0;
         src_ff      <= '0;
         act_ok_ff   <= 1'b0;
         act_ff      <= '0;
         use_ff      <= '0;
         for (int i = 0; i < PENDING_SLOTS; i++) begin
            sid_ff[i]  <= '0;
            arr_ff[i]  <= '0;
            tot_ff[i]  <= '0;
            slen_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else if (step) begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         plen_ff     <= plen_in;
         sum_ff      <= sum_in;
         id_ff       <= id_in;
         mf_ff       <= mf_in;
         fo_ff       <= fo_in;
         src_ff      <= src_in;
         act_ok_ff   <= act_ok_in;
         act_ff      <= act_in;
         use_ff      <= use_in;
         for (int i = 0; i < PENDING_SLOTS; i++) begin
            sid_ff[i]  <= sid_in[i];
            arr_ff[i]  <= arr_in[i];
            tot_ff[i]  <= tot_in[i];
            slen_ff[i] <= slen_in[i];
            cnt_ff[i]  <= cnt_in[i];
         end
      end
   end

   logic        offered, last;
   logic [7:0]  data;
   logic [16:0] sum_wide;
   logic [15:0] pos_inc, alen, pbase;
   logic        addr_ok, do_restart, claim_ok, done_act;
   logic [SLOT_IW-1:0] claim_idx;
   logic        claim_new, idx1;
   logic [2:0]  pk;
   logic [15:0] plen_tmp;

   function automatic logic [7:0] prefix_byte(input logic [2:0] k, input logic [31:0] src,
                                              input logic [15:0] len);
      case (k)
         3'd0: prefix_byte = src[31:24];
         3'd1: prefix_byte = src[23:16];
         3'd2: prefix_byte = src[15:8];
         3'd3: prefix_byte = src[7:0];
         3'd4: prefix_byte = len[15:8];
         default: prefix_byte = len[7:0];
      endcase
   endfunction

   always_comb begin
      offered = ~item.mode;
      data    = item.data_byte;
      last    = item.last_byte;

      phase_in = phase_ff; position_in = position_ff; plen_in = plen_ff;
      sum_in = sum_ff; id_in = id_ff; mf_in = mf_ff; fo_in = fo_ff; src_in = src_ff;
      act_ok_in = act_ok_ff; act_in = act_ff; use_in = use_ff;
      sid_in = sid_ff; arr_in = arr_ff; tot_in = tot_ff; slen_in = slen_ff; cnt_in = cnt_ff;
      result = '0;
      store_we = 1'b0;
      store_wdata = data;
      do_restart = 1'b0;
      sum_wide = '0; plen_tmp = '0;
      claim_ok = 1'b0; claim_idx = '0; claim_new = 1'b0; idx1 = 1'b0;
      pk = '0;

      // timers tick first
      for (int i = 0; i < PENDING_SLOTS; i++) begin
         if (use_ff[i] && !(tot_ff[i] != 8'd0 && arr_ff[i] == tot_ff[i])) begin
            if (cnt_ff[i] == 24'd0) use_in[i] = 1'b0;
            else cnt_in[i] = cnt_ff[i] - 24'd1;
         end
      end

      addr_ok  = act_ok_ff && (position_ff < 16'(SLOT_BYTES));
      pos_inc  = position_ff + 16'd1;
      alen     = act_ok_ff ? slen_ff[act_ff] : 16'd0;
      pbase    = {fo_ff, 3'b000};
      done_act = tot_in[act_ff] != 8'd0 && arr_in[act_ff] == tot_in[act_ff];
      store_addr = addr_ok ? STORE_AW'({act_ff, position_ff[SLOT_AW-1:0]}) : '0;

      case (phase_ff)
         PH_HEADER: begin
            if (offered) begin
               result.rsp.consumed = 1'b1;
               sum_wide = {1'b0, sum_ff} +
                          (position_ff[0] ? {9'd0, data} : {1'b0, data, 8'd0});
               sum_in = sum_wide[15:0] + {15'd0, sum_wide[16]};
               case (position_ff)
                  16'd2: plen_in = {data, 8'd0};
                  16'd3: plen_in = {plen_ff[15:8], data} - HDR_BYTES;
                  16'd4: id_in = {data, 8'd0};
                  16'd5: id_in = {id_ff[15:8], data};
                  16'd6: begin
                     mf_in = data[5];
                     fo_in = {data[4:0], 8'd0};
                  end
                  16'd7: fo_in = {fo_ff[12:8], data};
                  16'd12, 16'd13, 16'd14, 16'd15: src_in = {src_ff[23:0], data};
                  default: ;
               endcase
               position_in = pos_inc;
               if (pos_inc == HDR_BYTES) begin
                  idx1 = fo_ff == frag_unit;
                  if (sum_in != SUM_GOOD) begin
                     phase_in = PH_CSUM_ERR0;
                  end else if (fo_ff != 13'd0 && !idx1) begin
                     phase_in = PH_FRAG_ERR0;
                  end else if (mf_ff || fo_ff != 13'd0) begin
                     // same id first, else highest free slot
                     for (int i = 0; i < PENDING_SLOTS; i++) begin
                        if (!use_in[i]) begin
                           claim_ok = 1'b1; claim_idx = SLOT_IW'(i); claim_new = 1'b1;
                        end
                     end
                     for (int i = PENDING_SLOTS - 1; i >= 0; i--) begin
                        if (use_in[i] && sid_in[i] == id_ff) begin
                           claim_ok = 1'b1; claim_idx = SLOT_IW'(i); claim_new = 1'b0;
                        end
                     end
                     act_ok_in = claim_ok;
                     act_in    = claim_idx;
                     if (!claim_ok) begin
                        phase_in = PH_FRAG_ERR0;
                     end else begin
                        if (claim_new) begin
                           use_in[claim_idx] = 1'b1;
                           sid_in[claim_idx] = id_ff;
                           arr_in[claim_idx] = '0;
                           tot_in[claim_idx] = '0;
                           slen_in[claim_idx] = '0;
                           cnt_in[claim_idx] = expiry;
                        end
                        if (arr_in[claim_idx] != 8'hff)
                           arr_in[claim_idx] = arr_in[claim_idx] + 8'd1;
                        if (!mf_ff) tot_in[claim_idx] = idx1 && fo_ff != 13'd0 ? 8'd2 : 8'd1;
                        phase_in = PH_TO_STORE;
                        position_in = pbase;
                        slen_in[claim_idx] = slen_in[claim_idx] + plen_ff;
                     end
                  end else begin
                     phase_in = PH_PLAIN_PRE0;
                  end
               end
               if (last) begin
                  if (act_ok_in) use_in[act_in] = 1'b0;
                  do_restart = 1'b1;
               end
            end
         end
         PH_PLAIN_PRE0, PH_PLAIN_PRE1, PH_PLAIN_PRE2, PH_PLAIN_PRE3, PH_PLAIN_PRE4,
         PH_PLAIN_PRE5: begin
            pk = 3'(5'(phase_ff) - 5'(PH_PLAIN_PRE0));
            result.rsp.out_valid = 1'b1;
            result.rsp.out_byte  = prefix_byte(pk, src_ff, plen_ff);
            phase_in = phase_type'(5'(phase_ff) + 5'd1);
         end
         PH_PLAIN: begin
            if (offered) begin
               result.rsp.consumed  = 1'b1;
               result.rsp.out_valid = 1'b1;
               result.rsp.out_byte  = data;
               result.rsp.out_last  = last;
               position_in = pos_inc;
               if (last) begin
                  result.rsp.error = (pos_inc - HDR_BYTES) != plen_ff;
                  do_restart = 1'b1;
               end
            end
         end
         PH_TO_STORE: begin
            if (offered) begin
               result.rsp.consumed = 1'b1;
               store_we = addr_ok;
               position_in = pos_inc;
               if (last) begin
                  plen_tmp = pbase + plen_ff;
                  if (pos_inc != plen_tmp) begin
                     result.rsp.error = 1'b1;
                     if (act_ok_ff) use_in[act_ff] = 1'b0;
                     do_restart = 1'b1;
                  end else if (act_ok_ff && done_act) begin
                     phase_in = PH_STORE_PRE0;
                     position_in = '0;
                  end else begin
                     do_restart = 1'b1;
                  end
               end
            end
         end
         PH_STORE_PRE0, PH_STORE_PRE1, PH_STORE_PRE2, PH_STORE_PRE3, PH_STORE_PRE4,
         PH_STORE_PRE5: begin
            pk = 3'(5'(phase_ff) - 5'(PH_STORE_PRE0));
            result.rsp.out_valid = 1'b1;
            result.rsp.out_byte  = prefix_byte(pk, src_ff, alen);
            phase_in = phase_type'(5'(phase_ff) + 5'd1);
         end
         PH_FROM_STORE: begin
            result.rsp.out_valid = 1'b1;
            result.from_store = addr_ok;
            if (position_ff == alen - 16'd1) begin
               result.rsp.out_last = 1'b1;
               if (act_ok_ff) use_in[act_ff] = 1'b0;
               do_restart = 1'b1;
            end else begin
               position_in = pos_inc;
            end
         end
         PH_CSUM_ERR0, PH_FRAG_ERR0: begin
            result.rsp.out_valid = 1'b1;
            result.rsp.out_byte  = plen_ff[15:8];
            phase_in = phase_type'(5'(phase_ff) + 5'd1);
         end
         PH_CSUM_ERR1, PH_FRAG_ERR1: begin
            result.rsp.out_valid = 1'b1;
            result.rsp.out_byte  = plen_ff[7:0];
            result.rsp.out_last  = 1'b1;
            result.rsp.error     = 1'b1;
            phase_in = PH_WAIT_END;
         end
         PH_WAIT_END: begin
            if (offered) begin
               result.rsp.consumed = 1'b1;
               if (last) do_restart = 1'b1;
            end
         end
         default: do_restart = 1'b1;
      endcase

      if (do_restart) begin
         phase_in = PH_HEADER; position_in = '0; plen_in = '0; sum_in = '0;
         id_in = '0; mf_in = 1'b0; fo_in = '0; act_ok_in = 1'b0; act_in = '0;
      end
      store_we = store_we && step;
   end

   a_ok_slot: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FROM_STORE) |-> act_ok_ff)
      else $error("store readout without active slot");
   a_store_last: assert property (@(posedge clock) disable iff (reset)
      (step && result.rsp.out_last && phase_ff == PH_FROM_STORE) |=> phase_ff == PH_HEADER)
      else $error("readout did not return to header");
   a_cons: assert property (@(posedge clock) disable iff (reset)
      (result.rsp.consumed) |-> !item.mode)
      else $error("idle item consumed");

endmodule

// File: design/ipv4r_store.sv
// ----------------------------------------------------------------------------
// ipv4r_store
// Back part: reassembly store and result queue toward the receiver.
// ----------------------------------------------------------------------------
module ipv4r_store
   import ipv4r_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  stage_type           result,
   input  logic                store_we,
   input  logic [STORE_AW-1:0] store_addr,
   input  logic [7:0]          store_wdata,
   input  logic                pop,
   output logic                room,
   output logic                empty,
   output rsp_type             rsp_data
);

   logic [7:0] mem [STORE_BYTES];
   logic [7:0] rdata_ff;
   stage_type  stage_ff;
   logic       stage_v_ff;

   always_ff @(posedge clock) begin
      if (store_we) mem[store_addr] <= store_wdata;
      rdata_ff <= mem[store_addr];
   end

   rsp_type    q_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wp_ff, rp_ff;
   logic [QUEUE_AW:0]   cnt_ff, cnt_in;
   logic       push_q, pop_q;
   rsp_type    merged;

   always_comb begin
      merged = stage_ff.rsp;
      if (stage_ff.from_store) merged.out_byte = rdata_ff;
      push_q = stage_v_ff;
      pop_q  = pop && cnt_ff != '0;
      cnt_in = cnt_ff + (push_q ? 1'b1 : 1'b0) - (pop_q ? 1'b1 : 1'b0);
      // the item in the read stage counts against the queue
      room   = cnt_ff + (stage_v_ff ? 1'b1 : 1'b0) < (QUEUE_AW+1)'(QUEUE_DEPTH);
      empty  = cnt_ff == '0;
      rsp_data = q_ff[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= 1'b0;
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         stage_v_ff <= step;
         if (push_q) wp_ff <= wp_ff + 1'b1;
         if (pop_q) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= result;
      if (push_q) q_ff[wp_ff] <= merged;
   end

   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("result queue overflow");
   a_push_cnt: assert property (@(posedge clock) disable iff (reset)
      (push_q && !pop_q) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count off");
   a_room: assert property (@(posedge clock) disable iff (reset)
      step |-> room)
      else $error("item taken without room");

endmodule

// File: design/ipv4_receive_reassembler.sv
// ----------------------------------------------------------------------------
// ipv4_receive_reassembler
// IPv4 receive path with two-fragment reassembly.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: push an item (mode, data_byte, last_byte) while full is low.
//   Every accepted item yields exactly one result item on the rsp_ channel,
//   read while empty is low and taken with pop. A result with consumed low
//   means the offered byte was not taken and must be offered again.
//   csr_ port: write fragment_offset_unit (index 0) or expiry_ticks (index 1)
//   only while the block is idle.
// A result passes the read stage and then the result queue before it can be
//   popped; the parser works in the accepting cycle, the store read in the next.
// Throughput: one item per cycle while full is low; the store has a single port.
// Reset clears the parser and the pending table; the store holds no reset.
// When the receiver stalls, full rises once four results wait in the read
//   stage and the four-entry result queue; intake resumes as soon as pop
//   frees room.
// ----------------------------------------------------------------------------
module ipv4_receive_reassembler
   import ipv4r_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  req_type     req_item,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_item,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [23:0] csr_wdata
);

   logic [12:0] frag_unit_ff;
   logic [23:0] expiry_ff;
   logic        room, step;
   stage_type   result;
   logic        store_we;
   logic [STORE_AW-1:0] store_addr;
   logic [7:0]  store_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         frag_unit_ff <= FRAG_UNIT_RESET;
         expiry_ff    <= EXPIRY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAG_UNIT: frag_unit_ff <= csr_wdata[12:0];
            CSR_EXPIRY:    expiry_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign full = ~room;
   assign step = push & room;

   ipv4r_engine u_engine (
      .clock, .reset, .step, .item(req_item),
      .frag_unit(frag_unit_ff), .expiry(expiry_ff),
      .result, .store_we, .store_addr, .store_wdata
   );

   ipv4r_store u_store (
      .clock, .reset, .step, .result, .store_we, .store_addr, .store_wdata,
      .pop, .room, .empty, .rsp_data(rsp_item)
   );

endmodule
